/* rtl/cbm_pkg.sv */
`timescale 1ns / 1ps

package cbm_pkg;

    // Physical address widths of the attached ROM and RAM.
    localparam int ROM_ADDRESS_BITS = 23;
    localparam int RAM_ADDRESS_BITS = 17;

    localparam int PHYS_W    = 23;
    localparam int CLOCK_REGS = 5;
    localparam int CLOCK_IDX_W = $clog2(CLOCK_REGS);

    localparam logic [PHYS_W-1:0] ROM_MASK = PHYS_W'((64'd1 << ROM_ADDRESS_BITS) - 64'd1);
    localparam logic [PHYS_W-1:0] RAM_MASK = PHYS_W'((64'd1 << RAM_ADDRESS_BITS) - 64'd1);

    localparam logic [7:0] OPEN_BUS   = 8'hFF;
    localparam logic [3:0] ENABLE_KEY = 4'hA;

    typedef enum logic [2:0] {
        MAP_NONE = 3'd0,
        MAP_MBC1 = 3'd1,
        MAP_MBC2 = 3'd2,
        MAP_MBC3 = 3'd3,
        MAP_MBC5 = 3'd4
    } cbm_kind_t;

    typedef enum logic [1:0] {
        TGT_NONE  = 2'd0,
        TGT_ROM   = 2'd1,
        TGT_RAM   = 2'd2,
        TGT_CLOCK = 2'd3
    } cbm_target_t;

    // Configuration register indexes.
    localparam logic CFG_MAPPER_KIND  = 1'b0;
    localparam logic CFG_HAS_CART_RAM = 1'b1;

    typedef struct packed {
        logic       ram_enabled;
        logic [8:0] rom_bank;
        logic [7:0] ram_bank;
        logic       banking_mode;
    } cbm_state_t;

    typedef struct packed {
        logic                   en;
        logic [CLOCK_IDX_W-1:0] idx;
        logic [7:0]             data;
    } cbm_clk_wr_t;

    typedef struct packed {
        cbm_target_t       target;
        logic [PHYS_W-1:0] physical_address;
        logic [7:0]        read_data;
        logic              nibble_only;
    } cbm_result_t;

endpackage

/* rtl/cartridge_bank_mapper_unit.sv */
`timescale 1ns / 1ps

// Cartridge bank controller. Each word on the s_ channel is one CPU bus access:
// s_tuser is the direction (0 read, 1 write), s_tdata carries the address and
// the write byte. Each access gives exactly one result word on the m_ channel
// naming the target (open bus, ROM, cartridge RAM or clock register), the
// physical byte address after banking, register read data and the nibble mark.
// Bank-register writes take effect for the very next access.
// The result is registered: an accepted word shows on m_tvalid in the cycle after it.
// Throughput is one word per cycle while the receiver keeps m_tready high; the decode
// and bank concatenation sit between the input handshake and the result register.
// When the receiver stalls, the result register holds and s_tready drops only
// while a held result is not being taken in the same cycle.
// Synchronous reset (aresetn low) empties the result register, sets the mapper
// kind to none with no cartridge RAM, RAM disabled, ROM bank 1, RAM bank 0,
// banking mode 0 and all clock registers to zero.
// The configuration port writes mapper kind (index 0) and RAM presence
// (index 1); write it only while no access is in flight.

module cartridge_bank_mapper_unit
    import cbm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [2:0]  cfg_wr_data,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // bus_address[15:0], write_data[23:16]
    input  logic        s_tuser,   // mode[0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // physical_address[22:0], read_data[30:23], zero[31]
    output logic [2:0]  m_tuser    // target[1:0], nibble_only[2]
);

    cbm_kind_t                  mapper_kind_reg;
    logic                       has_cart_ram_reg;
    cbm_state_t                 state_reg;
    cbm_state_t                 state_next;
    logic [CLOCK_REGS-1:0][7:0] clock_reg;
    cbm_clk_wr_t                clk_wr;
    cbm_result_t                result_next;
    cbm_result_t                result_reg;
    logic                       m_tvalid_reg;
    logic                       in_accept;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    cbm_decode u_decode (
        .mapper_kind  (mapper_kind_reg),
        .has_cart_ram (has_cart_ram_reg),
        .state        (state_reg),
        .clock_regs   (clock_reg),
        .mode         (s_tuser),
        .bus_address  (s_tdata[15:0]),
        .write_data   (s_tdata[23:16]),
        .state_next   (state_next),
        .clk_wr       (clk_wr),
        .result       (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mapper_kind_reg        <= MAP_NONE;
            has_cart_ram_reg       <= 1'b0;
            state_reg.ram_enabled  <= 1'b0;
            state_reg.rom_bank     <= 9'd1;
            state_reg.ram_bank     <= 8'd0;
            state_reg.banking_mode <= 1'b0;
            clock_reg              <= '0;
            m_tvalid_reg           <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_MAPPER_KIND) mapper_kind_reg <= cbm_kind_t'(cfg_wr_data);
                else if (cfg_addr == CFG_HAS_CART_RAM) has_cart_ram_reg <= cfg_wr_data[0];
            end
            if (in_accept) begin
                state_reg    <= state_next;
                m_tvalid_reg <= 1'b1;
                if (clk_wr.en) clock_reg[clk_wr.idx] <= clk_wr.data;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, result_reg.read_data, result_reg.physical_address};
    assign m_tuser  = {result_reg.nibble_only, result_reg.target};

    a_nibble_is_ram: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] == TGT_RAM))
        else $error("nibble mark on a result that is not cartridge RAM");

    a_open_bus_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1:0] == TGT_NONE) |-> (m_tdata[30:23] == OPEN_BUS
                                                    && m_tdata[22:0] == 23'd0))
        else $error("open-bus result without 0xFF data and zero address");

    a_memory_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[1:0] == TGT_ROM || m_tuser[1:0] == TGT_RAM))
            |-> (m_tdata[30:23] == 8'd0))
        else $error("memory result carries register data");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while an undelivered result is held");

endmodule

/* rtl/cbm_decode.sv */
`timescale 1ns / 1ps

module cbm_decode
    import cbm_pkg::*;
(
    input  cbm_kind_t                        mapper_kind,
    input  logic                             has_cart_ram,
    input  cbm_state_t                       state,
    input  logic [CLOCK_REGS-1:0][7:0]       clock_regs,
    input  logic                             mode,
    input  logic [15:0]                      bus_address,
    input  logic [7:0]                       write_data,
    output cbm_state_t                       state_next,
    output cbm_clk_wr_t                      clk_wr,
    output cbm_result_t                      result
);

    logic             kind_known;
    logic             set_enable;
    logic [8:0]       rom_bank_sel;
    logic             ram_hit;
    logic [7:0]       ram_bank_sel;
    logic [12:0]      offset;
    logic [20:0]      ram_linear;
    logic [CLOCK_IDX_W-1:0] clk_idx;
    logic [7:0]       clk_value;

    // Clock registers sit at bank codes 8 through 12, so the low bits give the index.
    function automatic logic [CLOCK_IDX_W-1:0] ram_bank_sel_idx(input logic [7:0] bank);
        return bank[CLOCK_IDX_W-1:0];
    endfunction

    assign kind_known = mapper_kind inside {MAP_NONE, MAP_MBC1, MAP_MBC2, MAP_MBC3, MAP_MBC5};
    assign set_enable = (write_data[3:0] == ENABLE_KEY);
    assign offset     = bus_address[12:0];
    assign ram_linear = {ram_bank_sel, offset};
    assign clk_idx    = ram_bank_sel_idx(state.ram_bank);
    assign clk_value  = mode ? write_data : clock_regs[clk_idx];

    always_comb begin
        if (!bus_address[14]) begin
            rom_bank_sel = (mapper_kind == MAP_MBC1 && state.banking_mode)
                         ? {2'b00, state.ram_bank[1:0], 5'b00000} : 9'd0;
        end else if (mapper_kind == MAP_MBC1) begin
            rom_bank_sel = {2'b00, state.ram_bank[1:0], state.rom_bank[4:0]};
        end else if (mapper_kind == MAP_NONE) begin
            rom_bank_sel = 9'd1;
        end else begin
            rom_bank_sel = state.rom_bank;
        end
    end

    always_comb begin
        state_next = state;
        clk_wr     = '0;
        ram_hit    = 1'b0;
        ram_bank_sel = 8'd0;
        result.target           = TGT_NONE;
        result.physical_address = '0;
        result.read_data        = OPEN_BUS;
        result.nibble_only      = 1'b0;

        if (kind_known) begin
            if (!bus_address[15]) begin
                if (mode) begin
                    case (mapper_kind)
                        MAP_NONE: begin
                            if (bus_address[14:13] == 2'd0) state_next.ram_enabled = set_enable;
                        end
                        MAP_MBC1: begin
                            case (bus_address[14:13])
                                2'd0: state_next.ram_enabled = set_enable;
                                2'd1: state_next.rom_bank = {4'd0, (write_data[4:0] == 5'd0)
                                                            ? 5'd1 : write_data[4:0]};
                                2'd2: state_next.ram_bank = {6'd0, write_data[1:0]};
                                default: state_next.banking_mode = write_data[0];
                            endcase
                        end
                        MAP_MBC2: begin
                            // Address bit 8 separates the bank register from the enable.
                            if (!bus_address[14]) begin
                                if (bus_address[8]) begin
                                    state_next.rom_bank = {5'd0, (write_data[3:0] == 4'd0)
                                                          ? 4'd1 : write_data[3:0]};
                                end else begin
                                    state_next.ram_enabled = set_enable;
                                end
                            end
                        end
                        MAP_MBC3: begin
                            case (bus_address[14:13])
                                2'd0: state_next.ram_enabled = set_enable;
                                2'd1: state_next.rom_bank = {1'b0, (write_data == 8'd0)
                                                            ? 8'd1 : write_data};
                                2'd2: state_next.ram_bank = write_data;
                                default: ;
                            endcase
                        end
                        default: begin
                            case (bus_address[14:13])
                                2'd0: state_next.ram_enabled = set_enable;
                                2'd1: begin
                                    if (bus_address[12]) state_next.rom_bank[8] = write_data[0];
                                    else state_next.rom_bank[7:0] = write_data;
                                end
                                2'd2: state_next.ram_bank = {4'd0, write_data[3:0]};
                                default: ;
                            endcase
                        end
                    endcase
                end else begin
                    result.target           = TGT_ROM;
                    result.physical_address = {rom_bank_sel, bus_address[13:0]} & ROM_MASK;
                    result.read_data        = 8'd0;
                end
            end else if (bus_address[14:13] == 2'b01 && state.ram_enabled) begin
                case (mapper_kind)
                    MAP_MBC2: begin
                        // Built-in 512-nibble RAM mirrors across the window.
                        result.target           = TGT_RAM;
                        result.physical_address = {14'd0, offset[8:0]} & RAM_MASK;
                        result.read_data        = 8'd0;
                        result.nibble_only      = 1'b1;
                    end
                    MAP_MBC3: begin
                        if (state.ram_bank < 8'd4) begin
                            ram_hit      = 1'b1;
                            ram_bank_sel = state.ram_bank;
                        end else if (state.ram_bank >= 8'd8 && state.ram_bank <= 8'd12) begin
                            clk_wr.en   = mode;
                            clk_wr.idx  = clk_idx;
                            clk_wr.data = write_data;
                            result.target    = TGT_CLOCK;
                            result.read_data = clk_value;
                        end
                    end
                    MAP_MBC1: begin
                        ram_hit      = 1'b1;
                        ram_bank_sel = state.banking_mode ? {6'd0, state.ram_bank[1:0]} : 8'd0;
                    end
                    MAP_MBC5: begin
                        ram_hit      = 1'b1;
                        ram_bank_sel = {4'd0, state.ram_bank[3:0]};
                    end
                    default: begin
                        ram_hit = 1'b1;
                    end
                endcase
                if (ram_hit && has_cart_ram) begin
                    result.target           = TGT_RAM;
                    result.read_data        = 8'd0;
                    result.physical_address = {2'b00, ram_linear} & RAM_MASK;
                end
            end
        end
    end

endmodule
